// ===== sv/sfla_pkg.sv =====
// Package: shared types, constants and codes of the free-list allocator.
`default_nettype none
package sfla_pkg;
  localparam int unsigned MemWordsDef  = 65536;
  localparam int unsigned MaxBlockDef  = 256;
  localparam int unsigned WordBitsDef  = 32;
  localparam logic [16:0] ChunkReset   = 17'd4096;
  localparam logic [15:0] BaseReset    = 16'd1000;
  localparam logic [16:0] AddrSpace    = 17'h10000;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_ABANDON = 2'd1,
    FUNC_WRITE   = 2'd2,
    FUNC_READ    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_DIRTY = 2'd2,
    ST_OOM   = 2'd3
  } status_e;

  localparam logic REG_CHUNK = 1'b0;
  localparam logic REG_BASE  = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [8:0]  elem_words;
    logic        is_array;
    logic [15:0] array_len;
    logic [15:0] address;
    logic [8:0]  block_words;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [31:0] read_value;
    logic [1:0]  status;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    func_e       func;
    logic        too_big;
    logic        is_array;
    logic [15:0] array_len;
    logic [15:0] address;
    logic [12:0] size;
    logic [31:0] write_value;
  } cmd_t;
endpackage
`default_nettype wire

// ===== sv/sfla_front.sv =====
// Front end: accepts requests, computes block sizes, feeds the command queue.
`default_nettype none
module sfla_front #(
  parameter int unsigned MaxBlockWords = sfla_pkg::MaxBlockDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire sfla_pkg::req_t req_i,
  input  wire logic [16:0]   chunk_words_i,
  output sfla_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_take_i
);
  import sfla_pkg::*;

  localparam int unsigned QDepth = 2;

  logic [16:0] prod_q, prod_d;
  logic        mul_v_q;
  req_t        req_q;
  logic [24:0] total;
  logic        big;
  cmd_t        fifo_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        enq;

  // stage 1: register product of element size and count
  assign full_o = mul_v_q || (cnt_q == 2'(QDepth));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else begin
      mul_v_q <= push_i && !full_o;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      req_q  <= req_i;
      prod_q <= prod_d;
    end
  end
  logic [24:0] mul_full;
  assign mul_full = req_i.elem_words * req_i.array_len;
  assign prod_d = (mul_full > 25'h1FFFF) ? 17'h1FFFF : mul_full[16:0];

  always_comb begin
    if (req_q.is_array) total = 25'(prod_q) + 25'd2;
    else total = 25'(req_q.elem_words) + 25'd1;
  end
  always_comb begin
    if (req_q.func == FUNC_ABANDON)
      big = (req_q.block_words == 9'd0) || (32'(req_q.block_words) > MaxBlockWords);
    else if (req_q.func == FUNC_ALLOC)
      big = (total > 25'(chunk_words_i)) || (total > 25'(MaxBlockWords));
    else
      big = 1'b0;
  end

  assign enq = mul_v_q;
  always_ff @(posedge clk_i) begin
    if (enq) begin
      fifo_q[wp_q].func        <= func_e'(req_q.func);
      fifo_q[wp_q].too_big     <= big;
      fifo_q[wp_q].is_array    <= req_q.is_array;
      fifo_q[wp_q].array_len   <= req_q.array_len;
      fifo_q[wp_q].address     <= req_q.address;
      fifo_q[wp_q].size        <= (req_q.func == FUNC_ABANDON) ? 13'(req_q.block_words)
                                                               : total[12:0];
      fifo_q[wp_q].write_value <= req_q.write_value;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (enq) wp_q <= ~wp_q;
      if (cmd_take_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(enq) - 2'(cmd_take_i);
    end
  end
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = fifo_q[rp_q];
endmodule
`default_nettype wire

// ===== sv/sfla_back.sv =====
// Back end: walks blocks in the word store, keeps the free lists and chunk state.
`default_nettype none
module sfla_back #(
  parameter int unsigned MemWords      = sfla_pkg::MemWordsDef,
  parameter int unsigned MaxBlockWords = sfla_pkg::MaxBlockDef,
  parameter int unsigned WordBits      = sfla_pkg::WordBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sfla_pkg::cmd_t cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_take_o,
  input  wire logic [16:0]    chunk_words_i,
  input  wire logic [15:0]    base_i,
  input  wire logic           restart_i,
  output sfla_pkg::rsp_t      rsp_o,
  output logic                empty_o,
  input  wire logic           pop_i
);
  import sfla_pkg::*;

  // words reachable by a block that starts below the 16-bit address limit
  localparam int unsigned MemSpan = (MemWords < 32'h10000 + MaxBlockWords) ?
                                    MemWords : 32'h10000 + MaxBlockWords;
  localparam int unsigned AW = $clog2(MemSpan);
  localparam int unsigned HW = $clog2(MaxBlockWords + 1);
  localparam logic [16:0] Lim = (MemWords < 32'h10000) ? 17'(MemWords) : AddrSpace;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HEAD  = 7'b0000010,
    S_HEADW = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_ZERO  = 7'b0010000,
    S_READW = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [WordBits-1:0] mem [MemSpan];
  logic [WordBits-1:0] rdata_q;
  logic [15:0] heads [MaxBlockWords+1];
  logic [15:0] head_q;
  logic [MaxBlockWords:0] hvalid_q;

  logic [16:0] bump_q;
  logic [17:0] chunk_end_q, next_chunk_q;
  cmd_t        cmd_q;
  logic [16:0] start_q, addr_q;
  logic [1:0]  st_q;
  rsp_t        out_q;
  logic        full_q;

  logic        we;
  logic [16:0] wa;
  logic [WordBits-1:0] wd;
  logic        re;
  logic [16:0] ra;
  logic        re_q, rvalid_q;

  logic [HW-1:0] hidx;
  logic [15:0]   head_cur;
  logic [16:0]   end_addr, fit_end;
  logic [18:0]   fresh_end;

  assign hidx     = HW'(cmd_q.size);
  assign head_cur = hvalid_q[hidx] ? head_q : 16'd0;
  assign end_addr = start_q + 17'(cmd_q.size);
  assign fit_end  = bump_q + 17'(cmd_q.size);
  assign fresh_end = 19'(next_chunk_q) + 19'(chunk_words_i);

  always_ff @(posedge clk_i) begin
    if (we && 32'(wa) < MemSpan) mem[wa[AW-1:0]] <= wd;
    if (re) rdata_q <= (32'(ra) < MemSpan) ? mem[ra[AW-1:0]] : '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) re_q <= 1'b0;
    else re_q <= re;
  end
  assign rvalid_q = re_q;

  logic h_we;
  logic [15:0] h_wd;
  always_ff @(posedge clk_i) begin
    if (h_we) heads[hidx] <= h_wd;
    if (cmd_take_o) head_q <= heads[HW'(cmd_i.size)];
  end

  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i && !full_q;
  assign empty_o    = !full_q;
  assign rsp_o      = out_q;

  logic fin;
  rsp_t fin_rsp;

  always_comb begin
    state_d = state_q;
    we = 1'b0; wa = addr_q; wd = '0;
    re = 1'b0; ra = addr_q;
    h_we = 1'b0; h_wd = '0;
    fin = 1'b0; fin_rsp = '0;
    unique case (state_q)
      S_IDLE: ;
      S_HEAD: begin
        if (cmd_q.too_big) begin
          fin = 1'b1; fin_rsp.status = ST_SIZE;
        end else unique case (cmd_q.func)
          FUNC_WRITE: begin
            we = 1'b1; wa = 17'(cmd_q.address); wd = WordBits'(cmd_q.write_value);
            fin = 1'b1;
          end
          FUNC_READ: begin
            re = 1'b1; ra = 17'(cmd_q.address); state_d = S_READW;
          end
          FUNC_ABANDON: state_d = S_ZERO;
          FUNC_ALLOC: begin
            if (head_cur != 16'd0) begin
              re = 1'b1; ra = 17'(head_cur); state_d = S_HEADW;
            end else if (18'(fit_end) <= chunk_end_q) begin
              if (fit_end > Lim) begin
                fin = 1'b1; fin_rsp.status = ST_OOM;
              end else state_d = S_ZERO;
            end else if (fresh_end > 19'(Lim)) begin
              fin = 1'b1; fin_rsp.status = ST_OOM;
            end else state_d = S_ZERO;
          end
          default: ;
        endcase
      end
      S_HEADW: begin
        if (rvalid_q) begin
          h_we = 1'b1; h_wd = rdata_q[15:0];
          we = 1'b1; wa = start_q; wd = '0;
          state_d = S_CHECK;
          if (cmd_q.size > 13'd1) begin
            re = 1'b1; ra = start_q + 17'd1;
          end
        end
      end
      S_CHECK: begin
        // reads issued one per cycle; addr_q tracks next read address
        if (addr_q < end_addr) begin
          re = 1'b1; ra = addr_q;
        end
        if (!re_q) begin
          if (cmd_q.is_array) begin
            we = 1'b1; wa = start_q + 17'd1; wd = WordBits'(cmd_q.array_len);
          end
          fin = 1'b1; fin_rsp.result_address = start_q[15:0];
          fin_rsp.status = ((st_q == ST_DIRTY) || (rvalid_q && rdata_q != '0)) ?
                           ST_DIRTY : ST_OK;
        end
      end
      S_ZERO: begin
        we = 1'b1; wa = addr_q;
        if (addr_q == start_q && cmd_q.func == FUNC_ABANDON) wd = WordBits'(head_cur);
        if (addr_q == start_q + 17'd1 && cmd_q.func == FUNC_ALLOC && cmd_q.is_array)
          wd = WordBits'(cmd_q.array_len);
        if (addr_q + 17'd1 == end_addr) begin
          fin = 1'b1;
          if (cmd_q.func == FUNC_ABANDON) begin
            h_we = 1'b1; h_wd = start_q[15:0];
          end else fin_rsp.result_address = start_q[15:0];
        end
      end
      S_READW: begin
        if (rvalid_q) begin
          fin = 1'b1; fin_rsp.read_value = 32'(rdata_q);
        end
      end
      S_DONE: ;
      default: ;
    endcase
    if (fin) state_d = S_DONE;
    if (state_q == S_DONE && !full_q) state_d = S_IDLE;
    if (cmd_take_o) state_d = S_HEAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      full_q       <= 1'b0;
      hvalid_q     <= '0;
      bump_q       <= 17'(BaseReset);
      chunk_end_q  <= 18'(BaseReset) + 18'(ChunkReset);
      next_chunk_q <= 18'(BaseReset) + 18'(ChunkReset);
      st_q         <= ST_OK;
    end else begin
      state_q <= state_d;
      if (h_we) hvalid_q[hidx] <= 1'b1;
      if (fin) full_q <= 1'b1;
      else if (pop_i && full_q) full_q <= 1'b0;
      if (restart_i) begin
        bump_q       <= 17'(base_i);
        chunk_end_q  <= 18'(base_i) + 18'(chunk_words_i);
        next_chunk_q <= 18'(base_i) + 18'(chunk_words_i);
      end else if (state_q == S_HEAD && !cmd_q.too_big && cmd_q.func == FUNC_ALLOC
                   && head_cur == 16'd0) begin
        if (18'(fit_end) <= chunk_end_q) begin
          if (fit_end <= Lim) bump_q <= fit_end;
        end else if (fresh_end <= 19'(Lim)) begin
          bump_q       <= 17'(next_chunk_q) + 17'(cmd_q.size);
          next_chunk_q <= 18'(fresh_end);
          chunk_end_q  <= 18'(fresh_end);
        end
      end
      if (state_q == S_HEAD) st_q <= ST_OK;
      else if (state_q == S_CHECK && rvalid_q && rdata_q != '0) st_q <= ST_DIRTY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cmd_q <= cmd_i;
    if (fin) out_q <= fin_rsp;
    if (state_q == S_HEAD) begin
      if (cmd_q.func == FUNC_ABANDON) begin
        start_q <= 17'(cmd_q.address); addr_q <= 17'(cmd_q.address);
      end else if (head_cur != 16'd0) begin
        start_q <= 17'(head_cur); addr_q <= 17'(head_cur) + 17'd2;
      end else if (18'(fit_end) <= chunk_end_q) begin
        start_q <= bump_q; addr_q <= bump_q;
      end else begin
        start_q <= 17'(next_chunk_q); addr_q <= 17'(next_chunk_q);
      end
    end else if (state_q == S_CHECK && re) begin
      addr_q <= addr_q + 17'd1;
    end else if (state_q == S_ZERO) begin
      addr_q <= addr_q + 17'd1;
    end
  end
endmodule
`default_nettype wire

// ===== sv/segregated_free_list_allocator.sv =====
// Top level: segregated free-list allocator with APB register port.
// Each transaction passes a two-stage front end that sizes the request into a
// two-entry command queue; the back end then serves one command at a time on a
// word store with one read and one write port. An allocate or abandon makes one
// store access per block word (zero fill, or the check of a reused block), and
// the next command starts only after the previous result is popped.
`default_nettype none
module segregated_free_list_allocator #(
  parameter int unsigned MemWords      = sfla_pkg::MemWordsDef,
  parameter int unsigned MaxBlockWords = sfla_pkg::MaxBlockDef,
  parameter int unsigned WordBits      = sfla_pkg::WordBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire sfla_pkg::req_t req_i,
  output logic                empty_o,
  input  wire logic           pop_i,
  output sfla_pkg::rsp_t      rsp_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sfla_pkg::*;

  logic [16:0] chunk_q;
  logic [15:0] base_q;
  logic        wr_en, restart;
  cmd_t        cmd;
  logic        cmd_valid, cmd_take;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && paddr[2] == REG_BASE;
  assign prdata  = (paddr[2] == REG_BASE) ? {16'd0, base_q} : {15'd0, chunk_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= ChunkReset;
      base_q  <= BaseReset;
    end else if (wr_en) begin
      if (paddr[2] == REG_CHUNK) chunk_q <= pwdata[16:0];
      else base_q <= pwdata[15:0];
    end
  end

  sfla_front #(.MaxBlockWords(MaxBlockWords)) u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .req_i,
    .chunk_words_i(chunk_q), .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take)
  );

  sfla_back #(.MemWords(MemWords), .MaxBlockWords(MaxBlockWords), .WordBits(WordBits))
  u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .chunk_words_i(chunk_q), .base_i(pwdata[15:0]), .restart_i(restart),
    .rsp_o, .empty_o, .pop_i
  );
endmodule
`default_nettype wire

// ===== sv/sfla_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
`default_nettype none
module sfla_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           empty_o,
  input wire logic           pop_i,
  input wire sfla_pkg::rsp_t rsp_o,
  input wire logic           pready
);
  import sfla_pkg::*;

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(rsp_o)))
    else $error("result changed while waiting");
  a_err_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (rsp_o.status == ST_SIZE || rsp_o.status == ST_OOM))
      |-> rsp_o.result_address == 16'd0)
    else $error("failed allocate returned an address");
  a_err_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && rsp_o.status != ST_OK) |-> rsp_o.read_value == 32'd0)
    else $error("error result carries read data");
endmodule

bind segregated_free_list_allocator sfla_checker u_chk (
  .clk_i, .rst_ni, .empty_o, .pop_i, .rsp_o, .pready
);
`default_nettype wire

// ===== dv/segregated_free_list_allocator_tb.sv =====
// Testbench: random and directed traffic on the allocator, checked against a behavioral heap model.
`timescale 1ns / 100ps
module segregated_free_list_allocator_tb;
  import sfla_pkg::*;

  typedef struct {
    int unsigned a;
    int unsigned n;
  } blk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  req_t        req_i = '0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  rsp_t        rsp_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  segregated_free_list_allocator dut (
    .clk_i, .rst_ni, .push_i, .full_o, .req_i, .empty_o, .pop_i, .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // heap model state
  int unsigned chunk_sz = ChunkReset;
  int unsigned base_adr = BaseReset;
  int unsigned bump, chunk_lim, chunk_next;
  logic [15:0] heads [0:256];
  logic [31:0] heap [0:65535];
  bit          heap_set [0:65535];

  req_t        pending [$];
  rsp_t        expected_rsp [$];
  blk_t        live_blks [$];
  blk_t        freed_blks [$];
  int          errors = 0;
  int          tx_idle = 9;
  int          rx_idle = 64;
  bit          hold_go = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void heap_wr(longint unsigned a, logic [31:0] v);
    if (a < 65536) begin
      heap[a] = v;
      heap_set[a] = 1'b1;
    end
  endfunction

  function automatic logic [31:0] heap_rd(longint unsigned a);
    return (a < 65536) ? heap[a] : 32'd0;
  endfunction

  function automatic void restart_chunks();
    bump = base_adr;
    chunk_lim = base_adr + chunk_sz;
    chunk_next = chunk_lim;
  endfunction

  function automatic rsp_t heap_step(req_t r);
    rsp_t o;
    longint unsigned sz, st, a;
    blk_t b;
    o = '0;
    o.status = ST_OK;
    case (r.func)
      FUNC_ALLOC: begin
        sz = r.is_array ? 1 + longint'(r.elem_words) * longint'(r.array_len)
                        : longint'(r.elem_words);
        sz += 1;
        if (sz > chunk_sz || sz > 256) begin
          o.status = ST_SIZE;
        end else if (heads[sz] != 0) begin
          st = heads[sz];
          heads[sz] = 16'(heap_rd(st));
          for (a = st + 1; a < st + sz; a++)
            if (heap_rd(a) != 0) o.status = ST_DIRTY;
          heap_wr(st, 0);
          if (r.is_array) heap_wr(st + 1, 32'(r.array_len));
          o.result_address = 16'(st);
          b.a = 32'(st); b.n = 32'(sz);
          live_blks.insert(live_blks.size(), b);
        end else begin
          if (longint'(bump) + sz <= chunk_lim) begin
            if (longint'(bump) + sz > 65536) o.status = ST_OOM;
          end else if (longint'(chunk_next) + chunk_sz > 65536) begin
            o.status = ST_OOM;
          end else begin
            bump = chunk_next;
            chunk_next += chunk_sz;
            chunk_lim = chunk_next;
          end
          if (o.status == ST_OK) begin
            st = bump;
            for (a = st; a < st + sz; a++) heap_wr(a, 0);
            if (r.is_array) heap_wr(st + 1, 32'(r.array_len));
            bump = 32'(st + sz);
            o.result_address = 16'(st);
            b.a = 32'(st); b.n = 32'(sz);
            live_blks.insert(live_blks.size(), b);
          end
        end
      end
      FUNC_ABANDON: begin
        if (r.block_words == 0 || r.block_words > 256) begin
          o.status = ST_SIZE;
        end else begin
          st = r.address;
          for (a = st; a < st + r.block_words; a++) heap_wr(a, 0);
          heap_wr(st, 32'(heads[r.block_words]));
          heads[r.block_words] = 16'(st);
          b.a = 32'(st); b.n = 32'(r.block_words);
          freed_blks.insert(freed_blks.size(), b);
        end
      end
      FUNC_WRITE: heap_wr(r.address, r.write_value);
      default: o.read_value = heap_rd(r.address);
    endcase
    return o;
  endfunction

  // input side
  always @(negedge clk_i) begin
    if (rst_ni && pending.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
      push_i <= 1'b1;
      req_i <= pending[0];
    end else begin
      push_i <= 1'b0;
    end
  end

  // output side, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 600;
      pop_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= rst_ni && ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && push_i && !full_o) begin
      void'(pending.pop_front());
      expected_rsp.insert(expected_rsp.size(), heap_step(req_i));
    end
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %h", $time, rsp_o);
        errors++;
      end else begin
        exp_r = expected_rsp.pop_front();
        if (rsp_o.result_address !== exp_r.result_address) begin
          $display("%0t: result_address expected %h actual %h", $time,
                   exp_r.result_address, rsp_o.result_address);
          errors++;
        end
        if (rsp_o.read_value !== exp_r.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   exp_r.read_value, rsp_o.read_value);
          errors++;
        end
        if (rsp_o.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, rsp_o.status);
          errors++;
        end
      end
    end
  end

  task automatic put(req_t r);
    while (pending.size() > 1) @(posedge clk_i);
    pending.insert(pending.size(), r);
  endtask

  task automatic drain();
    while (pending.size() > 0 || expected_rsp.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] adr, logic [31:0] d);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= adr; pwdata <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_regs(int unsigned chunk, int unsigned base);
    drain();
    reg_write(3'd4 * REG_CHUNK, chunk);
    chunk_sz = chunk & 32'h1FFFF;
    reg_write(3'd4 * REG_BASE, base);
    base_adr = base & 32'hFFFF;
    restart_chunks();
  endtask

  function automatic req_t mk(func_e f, int unsigned ew, bit arr, int unsigned len,
                              int unsigned adr, int unsigned bw, logic [31:0] v);
    req_t r;
    r.func = f; r.elem_words = 9'(ew); r.is_array = arr; r.array_len = 16'(len);
    r.address = 16'(adr); r.block_words = 9'(bw); r.write_value = v;
    return r;
  endfunction

  task automatic rand_item();
    req_t r;
    blk_t b;
    int unsigned sel, adr, k;
    bit ok;
    r = '0;
    r.write_value = $urandom();
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      r.func = FUNC_ALLOC;
      r.elem_words = 9'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 511)
                                                     : $urandom_range(0, 8));
      r.is_array = ($urandom_range(0, 9) < 3);
      r.array_len = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 6));
      r.address = 16'($urandom());
      r.block_words = 9'($urandom());
    end else if (sel < 60) begin
      r.func = FUNC_ABANDON;
      r.elem_words = 9'($urandom());
      r.array_len = 16'($urandom());
      if (live_blks.size() > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, live_blks.size() - 1);
        b = live_blks[k];
        live_blks.delete(k);
        r.address = 16'(b.a);
        r.block_words = 9'(b.n);
      end else begin
        r.address = 16'($urandom());
        r.block_words = 9'($urandom_range(0, 511));
      end
    end else begin
      ok = 1'b0;
      if (freed_blks.size() > 0 && $urandom_range(0, 3) == 0) begin
        b = freed_blks[$urandom_range(0, freed_blks.size() - 1)];
        adr = b.a + $urandom_range(0, b.n - 1);
      end else if (live_blks.size() > 0 && $urandom_range(0, 1) == 0) begin
        b = live_blks[$urandom_range(0, live_blks.size() - 1)];
        adr = b.a + $urandom_range(0, b.n - 1);
      end else begin
        adr = $urandom_range(0, 65535);
      end
      adr &= 32'hFFFF;
      if (sel < 80) ok = 1'b0;
      else ok = heap_set[adr];
      r.func = ok ? FUNC_READ : FUNC_WRITE;
      r.address = 16'(adr);
      if ($urandom_range(0, 1)) r.write_value = $urandom_range(0, 3);
      r.elem_words = 9'($urandom());
      r.array_len = 16'($urandom());
      r.block_words = 9'($urandom());
    end
    put(r);
  endtask

  initial begin
    int unsigned chunks [6] = '{4096, 65536, 1, 256, 65536, 4096};
    int unsigned bases [6] = '{1000, 1, 65535, 30000, 65535, 1000};
    for (int i = 0; i <= 256; i++) heads[i] = '0;
    restart_chunks();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_regs(4096, 1000);

    put(mk(FUNC_WRITE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    put(mk(FUNC_WRITE, 0, 0, 0, 65535, 0, 32'h0));
    put(mk(FUNC_READ, 0, 0, 0, 0, 0, 0));
    put(mk(FUNC_READ, 0, 0, 0, 65535, 0, 0));
    put(mk(FUNC_ALLOC, 1, 0, 0, 0, 0, 0));
    put(mk(FUNC_ALLOC, 0, 0, 0, 0, 0, 0));
    put(mk(FUNC_ALLOC, 1, 1, 0, 0, 0, 0));
    put(mk(FUNC_ALLOC, 255, 0, 0, 0, 0, 0));
    put(mk(FUNC_ALLOC, 256, 0, 0, 0, 0, 0));
    put(mk(FUNC_ALLOC, 511, 1, 65535, 0, 0, 0));
    put(mk(FUNC_ALLOC, 2, 1, 3, 0, 0, 0));
    drain();
    put(mk(FUNC_ABANDON, 0, 0, 0, 1000, 2, 0));
    put(mk(FUNC_WRITE, 0, 0, 0, 1001, 0, 32'h1));
    put(mk(FUNC_ALLOC, 1, 0, 0, 0, 0, 0));
    put(mk(FUNC_ABANDON, 0, 0, 0, 1000, 2, 0));
    put(mk(FUNC_ALLOC, 0, 1, 0, 0, 0, 0));
    put(mk(FUNC_ABANDON, 0, 0, 0, 5000, 0, 0));
    put(mk(FUNC_ABANDON, 0, 0, 0, 5000, 300, 0));
    put(mk(FUNC_ABANDON, 0, 0, 0, 0, 2, 0));
    put(mk(FUNC_ABANDON, 0, 0, 0, 65535, 5, 0));
    put(mk(FUNC_ALLOC, 4, 0, 0, 0, 0, 0));
    put(mk(FUNC_READ, 0, 0, 0, 65535, 0, 0));

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle = (ph < 2) ? 9 : (ph < 4) ? 64 : 0;
      rx_idle = (ph < 2) ? 64 : (ph < 4) ? 9 : 0;
      if (ph > 0) set_regs(chunks[ph], bases[ph]);
      for (int n = 0; n < 320; n++) begin
        if (ph == 0 && n == 100) hold_go = ~hold_go;
        if (ph == 1 && n == 160) drain();
        rand_item();
      end
    end
    // out of memory once the store is nearly used up
    set_regs(65536, 65000);
    for (int n = 0; n < 8; n++) put(mk(FUNC_ALLOC, 200, 0, 0, 0, 0, 0));

    while (pending.size() > 0 || expected_rsp.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
